@@ design/haes_pkg.sv @@
package haes_pkg;

  // Histogram geometry
  localparam int BIN_COUNT      = 16;
  localparam int BIN_BITS       = 4;
  localparam int WEIGHT_BITS    = 3;
  localparam int COUNT_BITS_DEF = 24;

  // Total and weighted-sum headroom over one bin count
  localparam int TOTAL_GROW = 4;
  localparam int SUM_GROW   = 6;

  // Field widths
  localparam int VAL_BITS    = 16;
  localparam int EXT_BITS    = VAL_BITS + 2;
  localparam int STEP_BITS   = 12;
  localparam int THR_BITS    = 6;
  localparam int SETTLE_BITS = 2;
  localparam int VERD_BITS   = 2;

  // Configuration port
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [BIN_BITS-1:0] LAST_BIN = BIN_BITS'(BIN_COUNT - 1);

  // Register reset values
  localparam logic [VAL_BITS-1:0]    RST_EXPOSURE_MIN = 16'd1;
  localparam logic [VAL_BITS-1:0]    RST_EXPOSURE_MAX = 16'd65535;
  localparam logic [VAL_BITS-1:0]    RST_GAIN_MIN     = 16'd100;
  localparam logic [VAL_BITS-1:0]    RST_GAIN_MAX     = 16'd65535;
  localparam logic [STEP_BITS-1:0]   RST_STEP_SIZE    = 12'd130;
  localparam logic [THR_BITS-1:0]    RST_LOW_THR      = 6'd23;
  localparam logic [THR_BITS-1:0]    RST_HIGH_THR     = 6'd27;
  localparam logic [SETTLE_BITS-1:0] RST_SETTLE       = 2'd2;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_EXPOSURE_MIN = 3'd0,
    REG_EXPOSURE_MAX = 3'd1,
    REG_GAIN_MIN     = 3'd2,
    REG_GAIN_MAX     = 3'd3,
    REG_STEP_SIZE    = 3'd4,
    REG_LOW_THR      = 3'd5,
    REG_HIGH_THR     = 3'd6,
    REG_SETTLE       = 3'd7
  } cfg_reg_t;

  typedef enum logic [VERD_BITS-1:0] {
    VERDICT_IN_BAND = 2'd0,
    VERDICT_UNDER   = 2'd1,
    VERDICT_OVER    = 2'd2
  } verdict_t;

  typedef struct packed {
    logic [VAL_BITS-1:0]    exposure_min;
    logic [VAL_BITS-1:0]    exposure_max;
    logic [VAL_BITS-1:0]    gain_min;
    logic [VAL_BITS-1:0]    gain_max;
    logic [STEP_BITS-1:0]   step_size;
    logic [THR_BITS-1:0]    low_thr;
    logic [THR_BITS-1:0]    high_thr;
    logic [SETTLE_BITS-1:0] settle_frames;
  } cfg_t;

  // Group weight of a bin: five groups, weights 1 to 5
  function automatic logic [WEIGHT_BITS-1:0] bin_weight(input logic [BIN_BITS-1:0] idx);
    logic [WEIGHT_BITS-1:0] w;
    unique case (idx)
      4'd0, 4'd1, 4'd2:          w = 3'd1;
      4'd3, 4'd4, 4'd5:          w = 3'd2;
      4'd6, 4'd7, 4'd8, 4'd9:    w = 3'd3;
      4'd10, 4'd11, 4'd12:       w = 3'd4;
      default:                   w = 3'd5;
    endcase
    return w;
  endfunction

endpackage

@@ design/histogram_auto_exposure_step.sv @@
// Histogram auto exposure step.
// Input channel (in_valid / in_stall): one luma histogram bin per request,
// bins 0 to 15 of a frame in turn, one request per cycle when not stalled.
// in_current_exposure and in_current_gain are sampled with bin 15 only.
// Output channel (out_valid / out_stall): one request per frame that is not
// skipped, carrying the clamped exposure and gain and the verdict.
// The result is registered in turn in the frame register, the compare
// stage, the step stage and the clamp register. Throughput: one bin per
// cycle when not stalled, set by the single accumulate add per bin.
// After each result the following settle_frames frames give no result.
// A stalled receiver fills the four result stages and then the block
// raises in_stall; bins that do not end a frame still need room there.
// Reset (rst_n low, synchronous) clears the sums, the settle count and the
// stage valids, and loads the register defaults. Write configuration
// through cfg_we / cfg_index / cfg_data only while the block is idle.
module histogram_auto_exposure_step #(
  parameter int COUNT_BITS = haes_pkg::COUNT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [haes_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [haes_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [haes_pkg::BIN_BITS-1:0]       in_bin_index,
  input  logic [COUNT_BITS-1:0]               in_bin_count,
  input  logic [haes_pkg::VAL_BITS-1:0]       in_current_exposure,
  input  logic [haes_pkg::VAL_BITS-1:0]       in_current_gain,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [haes_pkg::VAL_BITS-1:0]       out_new_exposure,
  output logic [haes_pkg::VAL_BITS-1:0]       out_new_gain,
  output logic [haes_pkg::VERD_BITS-1:0]      out_exposure_verdict
);

  localparam int TOTAL_BITS = COUNT_BITS + haes_pkg::TOTAL_GROW;
  localparam int SUM_BITS   = COUNT_BITS + haes_pkg::SUM_GROW;

  haes_pkg::cfg_t                cfg_r, cfg_nxt;
  haes_pkg::cfg_reg_t            reg_sel;
  logic [haes_pkg::VAL_BITS-1:0] wr_val;

  logic                          fr_valid, fr_ready;
  logic [SUM_BITS-1:0]           fr_sum;
  logic [TOTAL_BITS-1:0]         fr_total;
  logic [haes_pkg::VAL_BITS-1:0] fr_exposure, fr_gain;

  // Register writes; a zero minimum falls back to its default
  assign reg_sel = haes_pkg::cfg_reg_t'(cfg_index);
  assign wr_val  = cfg_data[haes_pkg::VAL_BITS-1:0];

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (reg_sel)
        haes_pkg::REG_EXPOSURE_MIN:
          cfg_nxt.exposure_min = (wr_val == '0) ? haes_pkg::RST_EXPOSURE_MIN : wr_val;
        haes_pkg::REG_EXPOSURE_MAX: cfg_nxt.exposure_max = wr_val;
        haes_pkg::REG_GAIN_MIN:
          cfg_nxt.gain_min = (wr_val == '0) ? haes_pkg::RST_GAIN_MIN : wr_val;
        haes_pkg::REG_GAIN_MAX:  cfg_nxt.gain_max = wr_val;
        haes_pkg::REG_STEP_SIZE:
          cfg_nxt.step_size = cfg_data[haes_pkg::STEP_BITS-1:0];
        haes_pkg::REG_LOW_THR:
          cfg_nxt.low_thr = cfg_data[haes_pkg::THR_BITS-1:0];
        haes_pkg::REG_HIGH_THR:
          cfg_nxt.high_thr = cfg_data[haes_pkg::THR_BITS-1:0];
        haes_pkg::REG_SETTLE:
          cfg_nxt.settle_frames = cfg_data[haes_pkg::SETTLE_BITS-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.exposure_min  <= haes_pkg::RST_EXPOSURE_MIN;
      cfg_r.exposure_max  <= haes_pkg::RST_EXPOSURE_MAX;
      cfg_r.gain_min      <= haes_pkg::RST_GAIN_MIN;
      cfg_r.gain_max      <= haes_pkg::RST_GAIN_MAX;
      cfg_r.step_size     <= haes_pkg::RST_STEP_SIZE;
      cfg_r.low_thr       <= haes_pkg::RST_LOW_THR;
      cfg_r.high_thr      <= haes_pkg::RST_HIGH_THR;
      cfg_r.settle_frames <= haes_pkg::RST_SETTLE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Accumulate bins and hand finished frames on
  haes_accum #(
    .COUNT_BITS (COUNT_BITS)
  ) u_accum (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_bin_index        (in_bin_index),
    .in_bin_count        (in_bin_count),
    .in_current_exposure (in_current_exposure),
    .in_current_gain     (in_current_gain),
    .settle_frames       (cfg_r.settle_frames),
    .fr_valid            (fr_valid),
    .fr_ready            (fr_ready),
    .fr_sum              (fr_sum),
    .fr_total            (fr_total),
    .fr_exposure         (fr_exposure),
    .fr_gain             (fr_gain)
  );

  // Judge the frame and compute the new sensor settings
  haes_update #(
    .COUNT_BITS (COUNT_BITS)
  ) u_update (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg                  (cfg_r),
    .fr_valid             (fr_valid),
    .fr_ready             (fr_ready),
    .fr_sum               (fr_sum),
    .fr_total             (fr_total),
    .fr_exposure          (fr_exposure),
    .fr_gain              (fr_gain),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_new_exposure     (out_new_exposure),
    .out_new_gain         (out_new_gain),
    .out_exposure_verdict (out_exposure_verdict)
  );

endmodule

@@ design/haes_accum.sv @@
module haes_accum #(
  parameter int COUNT_BITS = haes_pkg::COUNT_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [haes_pkg::BIN_BITS-1:0]        in_bin_index,
  input  logic [COUNT_BITS-1:0]                in_bin_count,
  input  logic [haes_pkg::VAL_BITS-1:0]        in_current_exposure,
  input  logic [haes_pkg::VAL_BITS-1:0]        in_current_gain,
  input  logic [haes_pkg::SETTLE_BITS-1:0]     settle_frames,
  output logic                                 fr_valid,
  input  logic                                 fr_ready,
  output logic [COUNT_BITS+haes_pkg::SUM_GROW-1:0]   fr_sum,
  output logic [COUNT_BITS+haes_pkg::TOTAL_GROW-1:0] fr_total,
  output logic [haes_pkg::VAL_BITS-1:0]        fr_exposure,
  output logic [haes_pkg::VAL_BITS-1:0]        fr_gain
);

  localparam int TOTAL_BITS = COUNT_BITS + haes_pkg::TOTAL_GROW;
  localparam int SUM_BITS   = COUNT_BITS + haes_pkg::SUM_GROW;
  localparam int WPROD_BITS = COUNT_BITS + haes_pkg::WEIGHT_BITS;

  logic                               in_accept, last_bin, emit;
  logic [WPROD_BITS-1:0]              weighted;
  logic [TOTAL_BITS-1:0]              total_r, total_nxt, total_add;
  logic [SUM_BITS-1:0]                sum_r, sum_nxt, sum_add;
  logic [haes_pkg::SETTLE_BITS-1:0]   skip_r, skip_nxt;
  logic                               s1_v_r, s1_v_nxt;
  logic [SUM_BITS-1:0]                fr_sum_r;
  logic [TOTAL_BITS-1:0]              fr_total_r;
  logic [haes_pkg::VAL_BITS-1:0]      fr_exp_r, fr_gain_r;

  // Hold the request while the frame register cannot be handed on
  assign in_stall  = s1_v_r && !fr_ready;
  assign in_accept = in_valid && !in_stall;
  assign last_bin  = (in_bin_index == haes_pkg::LAST_BIN);
  assign emit      = in_accept && last_bin && (skip_r == '0);

  // Weight the bin and extend the running sums
  assign weighted  = WPROD_BITS'(in_bin_count)
                   * WPROD_BITS'(haes_pkg::bin_weight(in_bin_index));
  assign total_add = total_r + TOTAL_BITS'(in_bin_count);
  assign sum_add   = sum_r + SUM_BITS'(weighted);

  // Advance accumulators and settle count
  always_comb begin
    total_nxt = total_r;
    sum_nxt   = sum_r;
    skip_nxt  = skip_r;
    if (in_accept) begin
      if (last_bin) begin
        total_nxt = '0;
        sum_nxt   = '0;
        if (skip_r != '0) begin
          skip_nxt = skip_r - 1'b1;
        end else begin
          skip_nxt = settle_frames;
        end
      end else begin
        total_nxt = total_add;
        sum_nxt   = sum_add;
      end
    end
  end

  always_comb begin
    if (emit) begin
      s1_v_nxt = 1'b1;
    end else if (fr_ready) begin
      s1_v_nxt = 1'b0;
    end else begin
      s1_v_nxt = s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
      sum_r   <= '0;
      skip_r  <= '0;
      s1_v_r  <= 1'b0;
    end else begin
      total_r <= total_nxt;
      sum_r   <= sum_nxt;
      skip_r  <= skip_nxt;
      s1_v_r  <= s1_v_nxt;
    end
  end

  // Capture the finished frame
  always_ff @(posedge clk) begin
    if (emit) begin
      fr_sum_r   <= sum_add;
      fr_total_r <= total_add;
      fr_exp_r   <= in_current_exposure;
      fr_gain_r  <= in_current_gain;
    end
  end

  assign fr_valid    = s1_v_r;
  assign fr_sum      = fr_sum_r;
  assign fr_total    = fr_total_r;
  assign fr_exposure = fr_exp_r;
  assign fr_gain     = fr_gain_r;

`ifndef SYNTH
  a_clear_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && last_bin |=> total_r == '0 && sum_r == '0)
    else $error("accumulators not cleared at end of frame");

  a_skip_count: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && last_bin && skip_r != '0 |=>
      skip_r == haes_pkg::SETTLE_BITS'($past(skip_r) - 1'b1) && !$rose(s1_v_r))
    else $error("skipped frame mishandled");
`endif

endmodule

@@ design/haes_update.sv @@
module haes_update #(
  parameter int COUNT_BITS = haes_pkg::COUNT_BITS_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  haes_pkg::cfg_t                             cfg,
  input  logic                                       fr_valid,
  output logic                                       fr_ready,
  input  logic [COUNT_BITS+haes_pkg::SUM_GROW-1:0]   fr_sum,
  input  logic [COUNT_BITS+haes_pkg::TOTAL_GROW-1:0] fr_total,
  input  logic [haes_pkg::VAL_BITS-1:0]              fr_exposure,
  input  logic [haes_pkg::VAL_BITS-1:0]              fr_gain,
  output logic                                       out_valid,
  input  logic                                       out_stall,
  output logic [haes_pkg::VAL_BITS-1:0]              out_new_exposure,
  output logic [haes_pkg::VAL_BITS-1:0]              out_new_gain,
  output logic [haes_pkg::VERD_BITS-1:0]             out_exposure_verdict
);

  localparam int SUM_BITS  = COUNT_BITS + haes_pkg::SUM_GROW;
  localparam int PROD_BITS = SUM_BITS + 4;
  localparam int EXT       = haes_pkg::EXT_BITS;

  logic                 out_rdy, s3_rdy, s2_rdy, s2_load, s3_load, out_load;
  logic [PROD_BITS-1:0] sum_x10, low_x, high_x;
  logic                 nonempty, under_c, over_c;

  logic                          s2_v_r, s3_v_r, out_v_r;
  logic                          under_r, over_r;
  logic [haes_pkg::VAL_BITS-1:0] s2_exp_r, s2_gain_r;

  logic signed [EXT-1:0]  e0, g0, step_x, emax_x, gmin_x, emin_x, gmax_x;
  logic signed [EXT-1:0]  e_up, g_up, e_adj, g_adj;
  logic signed [EXT-1:0]  s3_exp_r, s3_gain_r;
  haes_pkg::verdict_t     verdict_c, s3_verdict_r;

  logic [haes_pkg::VAL_BITS-1:0]  exp_clamp, gain_clamp;
  logic [haes_pkg::VAL_BITS-1:0]  out_exp_r, out_gain_r;
  haes_pkg::verdict_t             out_verdict_r;

  // Stage hand-over: a stage moves on when the one after it has room
  assign out_rdy  = !out_v_r || !out_stall;
  assign s3_rdy   = !s3_v_r || out_rdy;
  assign s2_rdy   = !s2_v_r || s3_rdy;
  assign fr_ready = s2_rdy;
  assign s2_load  = fr_valid && s2_rdy;
  assign s3_load  = s2_v_r && s3_rdy;
  assign out_load = s3_v_r && out_rdy;

  // Compare mean with the thresholds by cross-multiplication
  assign sum_x10  = (PROD_BITS'(fr_sum) << 3) + (PROD_BITS'(fr_sum) << 1);
  assign low_x    = PROD_BITS'(fr_total) * PROD_BITS'(cfg.low_thr);
  assign high_x   = PROD_BITS'(fr_total) * PROD_BITS'(cfg.high_thr);
  assign nonempty = (fr_total != '0);
  assign under_c  = nonempty && (sum_x10 < low_x);
  assign over_c   = nonempty && (sum_x10 > high_x);

  // Step exposure and gain
  assign e0     = $signed({2'b00, s2_exp_r});
  assign g0     = $signed({2'b00, s2_gain_r});
  assign step_x = $signed(EXT'(cfg.step_size));
  assign emax_x = $signed({2'b00, cfg.exposure_max});
  assign gmin_x = $signed({2'b00, cfg.gain_min});
  assign emin_x = $signed({2'b00, cfg.exposure_min});
  assign gmax_x = $signed({2'b00, cfg.gain_max});

  always_comb begin
    e_up  = e0;
    g_up  = g0;
    if (under_r) begin
      e_up = e0 + step_x;
      if (e_up >= emax_x) begin
        g_up = g0 + step_x;
      end
    end
    e_adj = e_up;
    g_adj = g_up;
    if (over_r) begin
      if (e_up == emax_x && g_up != gmin_x) begin
        g_adj = g_up - step_x;
      end else begin
        e_adj = e_up - step_x;
      end
    end
  end

  always_comb begin
    priority if (under_r) begin
      verdict_c = haes_pkg::VERDICT_UNDER;
    end else if (over_r) begin
      verdict_c = haes_pkg::VERDICT_OVER;
    end else begin
      verdict_c = haes_pkg::VERDICT_IN_BAND;
    end
  end

  // Clamp, the maximum wins over the minimum
  always_comb begin
    priority if (s3_exp_r > emax_x) begin
      exp_clamp = cfg.exposure_max;
    end else if (s3_exp_r < emin_x) begin
      exp_clamp = cfg.exposure_min;
    end else begin
      exp_clamp = s3_exp_r[haes_pkg::VAL_BITS-1:0];
    end
    priority if (s3_gain_r > gmax_x) begin
      gain_clamp = cfg.gain_max;
    end else if (s3_gain_r < gmin_x) begin
      gain_clamp = cfg.gain_min;
    end else begin
      gain_clamp = s3_gain_r[haes_pkg::VAL_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s2_rdy) begin
        s2_v_r <= fr_valid;
      end
      if (s3_rdy) begin
        s3_v_r <= s2_v_r;
      end
      if (out_rdy) begin
        out_v_r <= s3_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      under_r   <= under_c;
      over_r    <= over_c;
      s2_exp_r  <= fr_exposure;
      s2_gain_r <= fr_gain;
    end
    if (s3_load) begin
      s3_exp_r     <= e_adj;
      s3_gain_r    <= g_adj;
      s3_verdict_r <= verdict_c;
    end
    if (out_load) begin
      out_exp_r     <= exp_clamp;
      out_gain_r    <= gain_clamp;
      out_verdict_r <= s3_verdict_r;
    end
  end

  assign out_valid            = out_v_r;
  assign out_new_exposure     = out_exp_r;
  assign out_new_gain         = out_gain_r;
  assign out_exposure_verdict = out_verdict_r;

`ifndef SYNTH
  a_empty_in_band: assert property (@(posedge clk) disable iff (!rst_n)
    s2_load && fr_total == '0 |=> !under_r && !over_r)
    else $error("empty histogram gave a verdict");

  a_result_moves: assert property (@(posedge clk) disable iff (!rst_n)
    s3_v_r && out_rdy |=> out_v_r)
    else $error("result lost between last two stages");
`endif

endmodule

@@ sim/exposure_step_checker.sv @@
module exposure_step_checker
  import haes_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic [BIN_BITS-1:0]      in_bin_index,
  input  logic [COUNT_BITS-1:0]    in_bin_count,
  input  logic [VAL_BITS-1:0]      in_current_exposure,
  input  logic [VAL_BITS-1:0]      in_current_gain,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic [VAL_BITS-1:0]      out_new_exposure,
  input  logic [VAL_BITS-1:0]      out_new_gain,
  input  logic [VERD_BITS-1:0]     out_exposure_verdict,
  input  logic                     run_over,
  output int                       expected_left,
  output int                       results_checked,
  output int                       fail_count
);

  localparam int TOT_W = COUNT_BITS + TOTAL_GROW;
  localparam int SUM_W = COUNT_BITS + SUM_GROW;

  typedef struct packed {
    logic [VAL_BITS-1:0] exposure;
    logic [VAL_BITS-1:0] gain;
    verdict_t            verdict;
  } exposure_update_t;

  // Own copy of the register file
  logic [VAL_BITS-1:0]    exp_floor, exp_ceiling, gain_floor, gain_ceiling;
  logic [STEP_BITS-1:0]   step_amt;
  logic [THR_BITS-1:0]    dark_thr, bright_thr;
  logic [SETTLE_BITS-1:0] settle_len;

  // Own copy of the frame accumulators and the settle counter
  logic [TOT_W-1:0]       pixel_total;
  logic [SUM_W-1:0]       weighted_total;
  logic [SETTLE_BITS-1:0] frames_to_skip;

  exposure_update_t pending_updates[$];
  bit               leftover_noted;

  always @(posedge clk) begin : watch
    logic [2:0]       weight;
    logic [TOT_W-1:0] frame_pixels;
    logic [SUM_W-1:0] frame_weighted;
    longint unsigned  scaled_sum, dark_limit, bright_limit;
    bit               dark, bright;
    int               e, g, e_lo, e_hi, g_lo, g_hi;
    exposure_update_t upd, seen;

    if (!rst_n) begin
      exp_floor      = RST_EXPOSURE_MIN;
      exp_ceiling    = RST_EXPOSURE_MAX;
      gain_floor     = RST_GAIN_MIN;
      gain_ceiling   = RST_GAIN_MAX;
      step_amt       = RST_STEP_SIZE;
      dark_thr       = RST_LOW_THR;
      bright_thr     = RST_HIGH_THR;
      settle_len     = RST_SETTLE;
      pixel_total    = '0;
      weighted_total = '0;
      frames_to_skip = '0;
      pending_updates.delete();
    end else begin
      // Track register writes; zero minimums fall back to their defaults
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_EXPOSURE_MIN: exp_floor = (cfg_data == '0) ? 16'd1 : cfg_data;
          REG_EXPOSURE_MAX: exp_ceiling = cfg_data;
          REG_GAIN_MIN:     gain_floor = (cfg_data == '0) ? RST_GAIN_MIN : cfg_data;
          REG_GAIN_MAX:     gain_ceiling = cfg_data;
          REG_STEP_SIZE:    step_amt = cfg_data[STEP_BITS-1:0];
          REG_LOW_THR:      dark_thr = cfg_data[THR_BITS-1:0];
          REG_HIGH_THR:     bright_thr = cfg_data[THR_BITS-1:0];
          REG_SETTLE:       settle_len = cfg_data[SETTLE_BITS-1:0];
          default: ;
        endcase
      end

      // Accumulate the bin; both sums wrap at their widths
      if (in_valid && !in_stall) begin
        weight = 3'((in_bin_index - in_bin_index / 4'd8) / 4'd3 + 4'd1);
        pixel_total    = pixel_total + TOT_W'(in_bin_count);
        weighted_total = weighted_total + SUM_W'(in_bin_count) * SUM_W'(weight);
        if (in_bin_index == LAST_BIN) begin
          frame_pixels   = pixel_total;
          frame_weighted = weighted_total;
          pixel_total    = '0;
          weighted_total = '0;
          if (frames_to_skip != '0) begin
            frames_to_skip = frames_to_skip - 1'b1;
          end else begin
            // Compare the mean with both thresholds by cross-multiplying
            scaled_sum   = 64'(frame_weighted) * 64'd10;
            dark_limit   = 64'(dark_thr) * 64'(frame_pixels);
            bright_limit = 64'(bright_thr) * 64'(frame_pixels);
            dark   = (frame_pixels != '0) && (scaled_sum < dark_limit);
            bright = (frame_pixels != '0) && (scaled_sum > bright_limit);
            e    = int'(in_current_exposure);
            g    = int'(in_current_gain);
            e_lo = int'(exp_floor);
            e_hi = int'(exp_ceiling);
            g_lo = int'(gain_floor);
            g_hi = int'(gain_ceiling);
            if (dark) begin
              e += int'(step_amt);
              if (e >= e_hi) g += int'(step_amt);
            end
            if (bright) begin
              if (e == e_hi && g != g_lo) g -= int'(step_amt);
              else e -= int'(step_amt);
            end
            // Clamp, the maximum winning over the minimum
            if (e > e_hi) e = e_hi;
            else if (e < e_lo) e = e_lo;
            if (g > g_hi) g = g_hi;
            else if (g < g_lo) g = g_lo;
            upd.exposure = e[VAL_BITS-1:0];
            upd.gain     = g[VAL_BITS-1:0];
            upd.verdict  = dark ? VERDICT_UNDER : (bright ? VERDICT_OVER : VERDICT_IN_BAND);
            pending_updates.push_back(upd);
            frames_to_skip = settle_len;
          end
        end
      end

      // Compare each delivered update with the oldest one predicted
      if (out_valid && !out_stall) begin
        seen.exposure = out_new_exposure;
        seen.gain     = out_new_gain;
        seen.verdict  = verdict_t'(out_exposure_verdict);
        if (pending_updates.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: update with none pending: exposure %0d gain %0d verdict %0d",
                     $time, seen.exposure, seen.gain, seen.verdict);
        end else begin
          upd = pending_updates.pop_front();
          results_checked++;
          if (seen.exposure !== upd.exposure || seen.gain !== upd.gain ||
              seen.verdict !== upd.verdict) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: update mismatch: exposure %0d/%0d gain %0d/%0d verdict %0d/%0d %s",
                       $time, upd.exposure, seen.exposure, upd.gain, seen.gain,
                       upd.verdict, seen.verdict, "(expected/actual)");
          end
        end
      end

      // Count updates that never turned up once stimulus is over
      if (run_over && !leftover_noted) begin
        leftover_noted = 1'b1;
        if (pending_updates.size() != 0) begin
          $display("%0d exposure update(s) never delivered", pending_updates.size());
          fail_count += pending_updates.size();
        end
      end
    end
    expected_left = pending_updates.size();
  end

endmodule

@@ sim/tb_histogram_auto_exposure_step.sv @@
module tb_histogram_auto_exposure_step;
  import haes_pkg::*;

  localparam int CNT_W       = COUNT_BITS_DEF;
  localparam int PHASE_ITEMS = 153;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [BIN_BITS-1:0]      in_bin_index = '0;
  logic [CNT_W-1:0]         in_bin_count = '0;
  logic [VAL_BITS-1:0]      in_current_exposure = '0;
  logic [VAL_BITS-1:0]      in_current_gain = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [VAL_BITS-1:0]      out_new_exposure;
  logic [VAL_BITS-1:0]      out_new_gain;
  logic [VERD_BITS-1:0]     out_exposure_verdict;
  logic                     run_over = 1'b0;

  int expected_left, results_checked, fail_count;

  // Stimulus bookkeeping and the settings in force, used to aim at corners
  int                  bins_sent, frames_sent, settings_done, burst_left;
  logic [VAL_BITS-1:0] exp_top, gain_bottom;
  logic [STEP_BITS-1:0] step_now;

  // Receiver stall pattern
  logic [7:0] stall_tick = '0;
  logic [1:0] stall_style = '0;

  histogram_auto_exposure_step #(.COUNT_BITS(CNT_W)) uut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_bin_index         (in_bin_index),
    .in_bin_count         (in_bin_count),
    .in_current_exposure  (in_current_exposure),
    .in_current_gain      (in_current_gain),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_new_exposure     (out_new_exposure),
    .out_new_gain         (out_new_gain),
    .out_exposure_verdict (out_exposure_verdict)
  );

  exposure_step_checker #(.COUNT_BITS(CNT_W)) checker_i (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_bin_index         (in_bin_index),
    .in_bin_count         (in_bin_count),
    .in_current_exposure  (in_current_exposure),
    .in_current_gain      (in_current_gain),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_new_exposure     (out_new_exposure),
    .out_new_gain         (out_new_gain),
    .out_exposure_verdict (out_exposure_verdict),
    .run_over             (run_over),
    .expected_left        (expected_left),
    .results_checked      (results_checked),
    .fail_count           (fail_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Stall the receiver in styles that change whenever stall_tick wraps to zero
  always @(posedge clk) begin
    stall_tick <= stall_tick + 1'b1;
    if (stall_tick == '0) stall_style <= 2'($urandom_range(0, 3));
    case (stall_style)
      2'd0: out_stall <= 1'b0;
      2'd1: out_stall <= ($urandom_range(0, 99) < 30);
      2'd2: out_stall <= ($urandom_range(0, 99) < 75);
      default: out_stall <= (stall_tick[3:0] < 4'd6);
    endcase
  end

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_BITS-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  // Write every register; narrow registers get junk in their unused bits
  task automatic apply_config(input logic [VAL_BITS-1:0] e_lo, e_hi, g_lo, g_hi,
                              input logic [STEP_BITS-1:0] step_val,
                              input logic [THR_BITS-1:0] low, high,
                              input logic [SETTLE_BITS-1:0] settle);
    write_reg(REG_EXPOSURE_MIN, e_lo);
    write_reg(REG_EXPOSURE_MAX, e_hi);
    write_reg(REG_GAIN_MIN, g_lo);
    write_reg(REG_GAIN_MAX, g_hi);
    write_reg(REG_STEP_SIZE, {4'($urandom), step_val});
    write_reg(REG_LOW_THR, {10'($urandom), low});
    write_reg(REG_HIGH_THR, {10'($urandom), high});
    write_reg(REG_SETTLE, {14'($urandom), settle});
    cfg_we      <= 1'b0;
    exp_top     = e_hi;
    gain_bottom = (g_lo == '0) ? RST_GAIN_MIN : g_lo;
    step_now    = step_val;
    settings_done++;
  endtask

  // Drop valid, let every pending update drain, then allow the pipeline to empty
  task automatic wait_idle();
    int guard;
    if (in_valid) in_valid <= 1'b0;
    @(posedge clk);
    guard = 0;
    while (expected_left != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
  endtask

  // Present one bin and hold it until taken; idle between bursts
  task automatic send_bin(input logic [BIN_BITS-1:0] idx, input logic [CNT_W-1:0] cnt,
                          input logic [VAL_BITS-1:0] cur_exp, cur_gain);
    int gap;
    in_valid            <= 1'b1;
    in_bin_index        <= idx;
    in_bin_count        <= cnt;
    in_current_exposure <= cur_exp;
    in_current_gain     <= cur_gain;
    do @(posedge clk); while (in_stall);
    bins_sent++;
    if (idx == LAST_BIN) frames_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 16);
    end
  endtask

  // Sensor value near an interesting point, or anywhere
  function automatic logic [VAL_BITS-1:0] pick_value(input logic [VAL_BITS-1:0] anchor);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3: return anchor;
      4: return anchor - VAL_BITS'(step_now);
      5: return anchor - VAL_BITS'(step_now) + VAL_BITS'($urandom_range(0, 2)) - 16'd1;
      default: return VAL_BITS'($urandom);
    endcase
  endfunction

  // Mostly whole frames, with stray bins and wrapping sums mixed in
  task automatic send_frame();
    int                  kind, style, focus, len;
    logic [VAL_BITS-1:0] e_now, g_now;
    logic [CNT_W-1:0]    cnt;
    kind  = $urandom_range(0, 99);
    e_now = pick_value(exp_top);
    g_now = pick_value(gain_bottom);
    if (kind < 78) begin
      style = $urandom_range(0, 6);
      focus = $urandom_range(0, BIN_COUNT - 1);
      for (int i = 0; i < BIN_COUNT; i++) begin
        case (style)
          0: cnt = CNT_W'($urandom);
          1: cnt = (i >= focus - 1 && i <= focus + 1) ? CNT_W'($urandom_range(0, 1 << 20))
                                                      : CNT_W'($urandom_range(0, 15));
          2: cnt = CNT_W'($urandom_range(0, 300));
          3: cnt = '0;
          4: cnt = (i == focus) ? CNT_W'($urandom_range(1, 5000)) : '0;
          5: cnt = '1;
          default: cnt = ($urandom_range(0, 1) == 0) ? '0 : CNT_W'($urandom_range(0, 65535));
        endcase
        if (i == BIN_COUNT - 1) send_bin(LAST_BIN, cnt, e_now, g_now);
        else send_bin(BIN_BITS'(i), cnt, VAL_BITS'($urandom), VAL_BITS'($urandom));
      end
    end else if (kind < 90) begin
      // Broken frame: bins out of order, end of frame optional
      len = $urandom_range(1, 10);
      repeat (len)
        send_bin(BIN_BITS'($urandom_range(0, BIN_COUNT - 2)), CNT_W'($urandom),
                 VAL_BITS'($urandom), VAL_BITS'($urandom));
      if ($urandom_range(0, 1) == 1) send_bin(LAST_BIN, CNT_W'($urandom), e_now, g_now);
    end else if (kind < 95) begin
      // Pile full bins onto the top groups until both sums wrap
      len = $urandom_range(17, 22);
      repeat (len)
        send_bin(BIN_BITS'($urandom_range(13, 14)), '1, VAL_BITS'($urandom),
                 VAL_BITS'($urandom));
      send_bin(LAST_BIN, '1, e_now, g_now);
    end else begin
      cnt = ($urandom_range(0, 1) == 1) ? CNT_W'($urandom) : '0;
      send_bin(LAST_BIN, cnt, e_now, g_now);
    end
  endtask

  initial begin
    int start;
    burst_left = $urandom_range(1, 16);
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: both thresholds crossed at once, all-max frame, empty histogram,
    // gain lowered at maximum exposure, gain raised at the exposure limit,
    // exposure lowered when gain already sits at its minimum
    apply_config(16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 12'd130, 6'd50, 6'd10, 2'd0);
    for (int i = 0; i < BIN_COUNT; i++)
      send_bin(BIN_BITS'(i), '1, 16'hFFFF, 16'd0);
    send_bin(LAST_BIN, '0, 16'd0, 16'd0);
    send_bin(LAST_BIN, '1, 16'hFFFF, 16'd500);
    send_bin(BIN_BITS'(0), CNT_W'(1), 16'd0, 16'hFFFF);
    send_bin(LAST_BIN, '0, 16'hFFFF - 16'd130, 16'hFFFF);
    send_bin(LAST_BIN, '1, 16'hFFFF, 16'd100);

    // Random phases, the first few at extreme settings
    for (int phase = 0; phase < 10; phase++) begin
      wait_idle();
      case (phase)
        0: apply_config(16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 12'd0, 6'd10, 6'd50, 2'd0);
        1: apply_config(16'd1, 16'hFFFF, 16'd1, 16'hFFFF, 12'hFFF, 6'd50, 6'd10, 2'd1);
        2: apply_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 12'hFFF, 6'd10, 6'd10, 2'd3);
        3: apply_config(16'd500, 16'd0, 16'd300, 16'd0, 12'd200, 6'd23, 6'd27, 2'd0);
        4: apply_config(RST_EXPOSURE_MIN, RST_EXPOSURE_MAX, RST_GAIN_MIN, RST_GAIN_MAX,
                        RST_STEP_SIZE, RST_LOW_THR, RST_HIGH_THR, RST_SETTLE);
        default:
          apply_config(VAL_BITS'($urandom_range(0, 4000)),
                       ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                   : VAL_BITS'($urandom_range(2000, 65535)),
                       VAL_BITS'($urandom_range(0, 800)),
                       ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                   : VAL_BITS'($urandom_range(500, 65535)),
                       ($urandom_range(0, 1) == 1) ? STEP_BITS'($urandom)
                                                   : STEP_BITS'($urandom_range(1, 300)),
                       THR_BITS'($urandom_range(10, 50)), THR_BITS'($urandom_range(10, 50)),
                       ($urandom_range(0, 1) == 1) ? 2'd0 : SETTLE_BITS'($urandom_range(0, 3)));
      endcase
      start = bins_sent;
      while (bins_sent - start < PHASE_ITEMS) send_frame();
    end

    wait_idle();
    run_over <= 1'b1;
    repeat (2) @(posedge clk);
    $display("Covered %0d bins in %0d frames under %0d register settings;",
             bins_sent, frames_sent, settings_done);
    $display("%0d exposure updates compared, %0d failure(s).", results_checked, fail_count);
    if (fail_count == 0) begin
      $display("histogram_auto_exposure_step verification clean");
    end else begin
      $display("histogram_auto_exposure_step verification failed");
    end
    $finish;
  end

  // Give up on a hung run
  initial begin
    #4000000;
    $display("histogram_auto_exposure_step verification failed");
    $finish;
  end

endmodule
